FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define RTQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// A condition in one cycle that requires a consequence in the next cycle.
`define RTQ_ASSERT_NEXT(lbl, cond, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/rtq_pkg.sv
// ----------------------------------------------------------------------------
// Repeating timer queue package
// Widths, operation codes, controller states and the structs that travel
// along the row of timer cells.
// ----------------------------------------------------------------------------
package rtq_pkg;

	localparam int DEPTH_DEF = 16;

	localparam int MODE_W = 2;
	localparam int NOW_W  = 48;
	localparam int DL_W   = 49;
	localparam int VAL_W  = 32;
	localparam int TID_W  = 16;

	typedef enum logic [MODE_W-1:0] {
		MODE_ADD   = 2'd0,
		MODE_POP   = 2'd1,
		MODE_QUERY = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		WR_NONE,
		WR_ADD,
		WR_REARM,
		WR_FREE
	} wr_op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_APPLY
	} rtq_state_t;

	// Running result of the sweep along the cells.
	typedef struct packed {
		logic             found;
		logic [DL_W-1:0]  deadline;
		logic [VAL_W-1:0] id;
		logic [VAL_W-1:0] interval;
		logic [VAL_W-1:0] runs;
		logic             free_found;
	} scan_t;

	// Update broadcast to all cells; only the addressed cell acts on it.
	typedef struct packed {
		wr_op_t           op;
		logic [DL_W-1:0]  deadline;
		logic [VAL_W-1:0] interval;
		logic [VAL_W-1:0] runs;
		logic [VAL_W-1:0] id;
	} cmd_t;

endpackage

FILE: hdl/rtq_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one timer operation per transfer.
// ----------------------------------------------------------------------------
interface rtq_req_if;
	import rtq_pkg::*;

	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	logic [NOW_W-1:0]  now_ms;
	logic [VAL_W-1:0]  period_ms;
	logic [VAL_W-1:0]  repeat_count;

	modport source (output valid, mode, now_ms, period_ms, repeat_count, input ready);
	modport sink (input valid, mode, now_ms, period_ms, repeat_count, output ready);

endinterface

FILE: hdl/rtq_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one operation result per transfer.
// ----------------------------------------------------------------------------
interface rtq_rsp_if;
	import rtq_pkg::*;

	logic              valid;
	logic              ready;
	logic              ok;
	logic [TID_W-1:0]  timer_id;
	logic [DL_W-1:0]   remain_ms;
	logic              fire_now;
	logic              queue_empty;
	logic              queue_full;
	logic              rearmed;

	modport source (output valid, ok, timer_id, remain_ms, fire_now, queue_empty,
		queue_full, rearmed, input ready);
	modport sink (input valid, ok, timer_id, remain_ms, fire_now, queue_empty,
		queue_full, rearmed, output ready);

endinterface

FILE: hdl/rtq_cell.sv
// ----------------------------------------------------------------------------
// Timer cell
// Holds one timer slot and passes the running earliest/free search result
// on to the next cell through a register every cycle.
// ----------------------------------------------------------------------------
module rtq_cell import rtq_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	parameter int INDEX = 0
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  scan_t                    scan_in,
	input  logic [$clog2(DEPTH)-1:0] slot_in,
	input  logic [$clog2(DEPTH)-1:0] free_slot_in,
	output scan_t                    scan_out,
	output logic [$clog2(DEPTH)-1:0] slot_out,
	output logic [$clog2(DEPTH)-1:0] free_slot_out,
	input  cmd_t                     cmd,
	input  logic [$clog2(DEPTH)-1:0] cmd_slot
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam logic [IDX_W-1:0] MY_SLOT = IDX_W'(INDEX);

	logic             valid_q;
	logic [DL_W-1:0]  deadline_q;
	logic [VAL_W-1:0] interval_q;
	logic [VAL_W-1:0] runs_q;
	logic [VAL_W-1:0] id_q;

	scan_t            scan_q;
	logic [IDX_W-1:0] slot_q;
	logic [IDX_W-1:0] free_slot_q;

	scan_t            scan_d;
	logic [IDX_W-1:0] slot_d;
	logic [IDX_W-1:0] free_slot_d;
	logic             better;
	logic             hit;

	assign hit = (cmd_slot == MY_SLOT);

	// Ties on deadline go to the lower id; full ties keep the earlier slot.
	assign better = valid_q && (!scan_in.found || (deadline_q < scan_in.deadline) ||
		((deadline_q == scan_in.deadline) && (id_q < scan_in.id)));

	always_comb begin
		scan_d      = scan_in;
		slot_d      = slot_in;
		free_slot_d = free_slot_in;
		if (better) begin
			scan_d.found    = 1'b1;
			scan_d.deadline = deadline_q;
			scan_d.id       = id_q;
			scan_d.interval = interval_q;
			scan_d.runs     = runs_q;
			slot_d          = MY_SLOT;
		end
		if (!valid_q && !scan_in.free_found) begin
			scan_d.free_found = 1'b1;
			free_slot_d       = MY_SLOT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q      <= '0;
			slot_q      <= '0;
			free_slot_q <= '0;
		end else begin
			scan_q      <= scan_d;
			slot_q      <= slot_d;
			free_slot_q <= free_slot_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (hit) begin
			case (cmd.op)
				WR_ADD:  valid_q <= 1'b1;
				WR_FREE: valid_q <= 1'b0;
				default: valid_q <= valid_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (hit) begin
			case (cmd.op)
				WR_ADD: begin
					deadline_q <= cmd.deadline;
					interval_q <= cmd.interval;
					runs_q     <= cmd.runs;
					id_q       <= cmd.id;
				end
				WR_REARM: begin
					deadline_q <= cmd.deadline;
					runs_q     <= cmd.runs;
				end
				default: begin
				end
			endcase
		end
	end

	assign scan_out      = scan_q;
	assign slot_out      = slot_q;
	assign free_slot_out = free_slot_q;

endmodule

FILE: hdl/rtq_ctrl.sv
// ----------------------------------------------------------------------------
// Timer queue controller
// Takes one operation, waits for the sweep along the cells, then issues the
// slot update and loads the response register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rtq_ctrl import rtq_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	rtq_req_if.sink                  req,
	rtq_rsp_if.source                rsp,
	input  scan_t                    scan,
	input  logic [$clog2(DEPTH)-1:0] scan_slot,
	input  logic [$clog2(DEPTH)-1:0] scan_free_slot,
	output cmd_t                     cmd,
	output logic [$clog2(DEPTH)-1:0] cmd_slot
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int OCC_W = $clog2(DEPTH + 1);
	localparam logic [IDX_W-1:0] LAST_CNT = IDX_W'(DEPTH - 1);
	localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(DEPTH);

	rtq_state_t        state_q;
	rtq_state_t        state_d;
	logic [IDX_W-1:0]  cnt_q;
	logic [MODE_W-1:0] mode_q;
	logic [NOW_W-1:0]  now_q;
	logic [VAL_W-1:0]  period_q;
	logic [VAL_W-1:0]  count_q;
	logic [OCC_W-1:0]  occ_q;
	logic [OCC_W-1:0]  occ_d;
	logic [VAL_W-1:0]  next_id_q;
	logic [VAL_W-1:0]  next_id_d;

	logic              rsp_valid_q;
	logic              ok_q;
	logic [TID_W-1:0]  tid_q;
	logic [DL_W-1:0]   remain_q;
	logic              fire_q;
	logic              empty_q;
	logic              full_q;
	logic              rearm_q;

	logic              ok_d;
	logic [TID_W-1:0]  tid_d;
	logic [DL_W-1:0]   remain_d;
	logic              fire_d;
	logic              full_d;
	logic              rearm_d;

	logic              accept;
	logic              out_free;
	logic              apply;
	logic [VAL_W-1:0]  addend;
	logic [DL_W-1:0]   new_deadline;
	logic [DL_W-1:0]   now_ext;
	logic [VAL_W-1:0]  runs_dec;
	logic              due;
	logic [VAL_W-1:0]  id_inc;

	assign accept   = req.valid && req.ready;
	assign out_free = !rsp_valid_q || rsp.ready;
	assign apply    = (state_q == ST_APPLY) && out_free;

	assign req.ready = (state_q == ST_IDLE);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (req.valid) state_d = ST_SCAN;
			ST_SCAN:  if (cnt_q == LAST_CNT) state_d = ST_APPLY;
			ST_APPLY: if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	assign now_ext      = {1'b0, now_q};
	assign addend       = (mode_q == MODE_ADD) ? period_q : scan.interval;
	assign new_deadline = now_ext + {{(DL_W - VAL_W){1'b0}}, addend};
	assign runs_dec     = scan.runs - 1'b1;
	assign due          = (scan.deadline <= now_ext);
	assign id_inc       = next_id_q + 1'b1;

	// Outputs: slot update and response fields.
	always_comb begin
		cmd          = '0;
		cmd.op       = WR_NONE;
		cmd_slot     = scan_slot;
		ok_d         = 1'b0;
		tid_d        = '0;
		remain_d     = '0;
		fire_d       = 1'b0;
		full_d       = 1'b0;
		rearm_d      = 1'b0;
		occ_d        = occ_q;
		next_id_d    = next_id_q;
		case (mode_q)
			MODE_ADD: begin
				if (scan.free_found) begin
					cmd.op       = WR_ADD;
					cmd.deadline = new_deadline;
					cmd.interval = period_q;
					cmd.runs     = count_q;
					cmd.id       = id_inc;
					cmd_slot     = scan_free_slot;
					ok_d         = 1'b1;
					tid_d        = id_inc[TID_W-1:0];
					occ_d        = occ_q + 1'b1;
					next_id_d    = id_inc;
				end else begin
					full_d = 1'b1;
				end
			end
			MODE_POP: begin
				if (scan.found) begin
					ok_d  = 1'b1;
					tid_d = scan.id[TID_W-1:0];
					if (runs_dec != '0) begin
						cmd.op       = WR_REARM;
						cmd.deadline = new_deadline;
						cmd.runs     = runs_dec;
						rearm_d      = 1'b1;
					end else begin
						cmd.op = WR_FREE;
						occ_d  = occ_q - 1'b1;
					end
				end
			end
			MODE_QUERY: begin
				if (scan.found) begin
					ok_d     = 1'b1;
					tid_d    = scan.id[TID_W-1:0];
					remain_d = due ? '0 : (scan.deadline - now_ext);
					fire_d   = due;
				end
			end
			default: begin
			end
		endcase
		if (!apply) begin
			cmd.op = WR_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			occ_q       <= '0;
			next_id_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				cnt_q <= '0;
			end else if (state_q == ST_SCAN) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (apply) begin
				occ_q       <= occ_d;
				next_id_q   <= next_id_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q   <= req.mode;
			now_q    <= req.now_ms;
			period_q <= req.period_ms;
			count_q  <= req.repeat_count;
		end
		if (apply) begin
			ok_q     <= ok_d;
			tid_q    <= tid_d;
			remain_q <= remain_d;
			fire_q   <= fire_d;
			empty_q  <= (occ_d == '0);
			full_q   <= full_d;
			rearm_q  <= rearm_d;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.ok          = ok_q;
	assign rsp.timer_id    = tid_q;
	assign rsp.remain_ms   = remain_q;
	assign rsp.fire_now    = fire_q;
	assign rsp.queue_empty = empty_q;
	assign rsp.queue_full  = full_q;
	assign rsp.rearmed     = rearm_q;

	`RTQ_ASSERT(a_occ_bound, occ_q <= FULL_OCC, "occupancy above store depth")
	`RTQ_ASSERT_NEXT(a_accept_scan, accept, (state_q == ST_SCAN) && (cnt_q == '0),
		"accepted request did not start a sweep")
	`RTQ_ASSERT_NEXT(a_add_count, apply && (cmd.op == WR_ADD),
		(occ_q == $past(occ_q) + 1'b1) && (next_id_q == $past(next_id_q) + 1'b1),
		"add did not advance occupancy and id")
	`RTQ_ASSERT(a_full_reject, rsp_valid_q && full_q |-> !ok_q && (occ_q == FULL_OCC),
		"full flag on an accepted add or a store with room")

endmodule

FILE: hdl/repeating_timer_queue.sv
// ----------------------------------------------------------------------------
// Repeating timer queue
// Scheduler for up to DEPTH repeating timers built as a row of timer cells.
// ----------------------------------------------------------------------------
// Requests arrive on req as valid/ready transfers: mode selects add, pop of
// the earliest timer, or query of the earliest remaining time, and now_ms
// carries the current time. Each request produces exactly one response
// transfer on rsp.
// After a request transfer the search result walks along the row of DEPTH
// cells, one cell per cycle; the controller then applies the slot update
// and loads the response register. A new request is taken only once the
// previous one has applied its update and the controller is idle again.
// Reset empties the store, clears the id counter and drops any response.
// A stalled response stays in its register; the next request is still taken
// and searched, and it waits at its update step until the response register
// is free, so the store never runs ahead of the delivered responses.
// ----------------------------------------------------------------------------
module repeating_timer_queue import rtq_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	rtq_req_if.sink   req,
	rtq_rsp_if.source rsp
);

	localparam int IDX_W = $clog2(DEPTH);

	scan_t            scan_chain [DEPTH+1];
	logic [IDX_W-1:0] slot_chain [DEPTH+1];
	logic [IDX_W-1:0] free_chain [DEPTH+1];
	cmd_t             cmd;
	logic [IDX_W-1:0] cmd_slot;

	assign scan_chain[0] = '0;
	assign slot_chain[0] = '0;
	assign free_chain[0] = '0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		rtq_cell #(
			.DEPTH (DEPTH),
			.INDEX (i)
		) u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.scan_in       (scan_chain[i]),
			.slot_in       (slot_chain[i]),
			.free_slot_in  (free_chain[i]),
			.scan_out      (scan_chain[i+1]),
			.slot_out      (slot_chain[i+1]),
			.free_slot_out (free_chain[i+1]),
			.cmd           (cmd),
			.cmd_slot      (cmd_slot)
		);
	end

	rtq_ctrl #(
		.DEPTH (DEPTH)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.req            (req),
		.rsp            (rsp),
		.scan           (scan_chain[DEPTH]),
		.scan_slot      (slot_chain[DEPTH]),
		.scan_free_slot (free_chain[DEPTH]),
		.cmd            (cmd),
		.cmd_slot       (cmd_slot)
	);

endmodule
